// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/aspa_pkg.sv -----
`default_nettype none

package aspa_pkg;

	localparam int STEP_W = 8;
	localparam int LVL_W  = 8;
	localparam int CNT_W  = 8;
	localparam int CMD_W  = 3;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INC        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEC        = 3'd1;
	localparam logic [CMD_W-1:0] CMD_OFF        = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FULL       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOAD_POWER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOAD_STEP  = 3'd5;

	// register indexes
	localparam logic [2:0] REG_STEP_MIN    = 3'd0;
	localparam logic [2:0] REG_STEP_MAX    = 3'd1;
	localparam logic [2:0] REG_STEP_FACTOR = 3'd2;
	localparam logic [2:0] REG_COUNT_LIMIT = 3'd3;
	localparam logic [2:0] REG_POWER_CEIL  = 3'd4;
	localparam logic [2:0] REG_POWER_IDLE  = 3'd5;
	localparam logic [2:0] REG_BYPASS      = 3'd6;

	// reset values
	localparam logic [STEP_W-1:0] STEP_MIN_RST    = 8'd1;
	localparam logic [STEP_W-1:0] STEP_MAX_RST    = 8'd64;
	localparam logic [STEP_W-1:0] STEP_FACTOR_RST = 8'd2;
	localparam logic [CNT_W-1:0]  COUNT_LIMIT_RST = 8'd3;
	localparam logic [LVL_W-1:0]  POWER_CEIL_RST  = 8'd255;
	localparam logic [LVL_W-1:0]  POWER_IDLE_RST  = 8'd0;
	localparam logic [STEP_W-1:0] STEP_RST        = 8'd16;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       operand;
	} cmd_item_t;

	typedef struct packed {
		logic [LVL_W-1:0]  power_level;
		logic [STEP_W-1:0] step_size;
		logic              accepted;
	} res_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_min;
		logic [STEP_W-1:0] step_max;
		logic [STEP_W-1:0] step_factor;
		logic [CNT_W-1:0]  count_limit;
		logic [LVL_W-1:0]  power_ceiling;
		logic [LVL_W-1:0]  power_idle;
		logic              bypass_bounds;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic mul;
		logic div_start;
		logic div_iter;
		logic div_end;
		logic apply;
		logic res_write;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_move;
		logic rev_hit;
	} dp_stat_t;

	function automatic logic step_in_bounds(input logic [STEP_W-1:0] v, input cfg_t c);
		step_in_bounds = c.bypass_bounds || ((v >= c.step_min) && (v <= c.step_max));
	endfunction

endpackage

`default_nettype wire

// ----- src/adaptive_step_power_adjuster.sv -----
`default_nettype none

// Adaptive-step heater power regulator. Each command transfer (increase,
// decrease, off, full, load power, load step) yields exactly one result
// transfer carrying the new power level, the current step and an accepted
// flag. Repeats in one direction grow the step by step_factor, reversals
// shrink it, each after count_limit events; steps outside [step_min,
// step_max] are refused unless bypass_bounds is set. Commands are handled one
// at a time by a small sequencer: off, full and both loads run exec and done;
// a move runs exec, multiply, apply and done, and one that shrinks the step
// adds divide start, iterate and end, the restoring divider giving one
// quotient bit per cycle. A new command is taken as soon as the sequencer is
// back in idle, even while the previous result still waits in the output
// register. Registers sit on an APB-style port, one per word; the user
// must write them only while no command is in flight; nothing enforces it.

`include "assert_macros.svh"

module adaptive_step_power_adjuster (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// apb register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [aspa_pkg::ADDR_W-1:0] paddr,
	input  wire logic [aspa_pkg::DATA_W-1:0] pwdata,
	output logic      [aspa_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	// command channel
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire aspa_pkg::cmd_item_t         cmd_item,
	// result channel
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output aspa_pkg::res_item_t              res_item
);
	import aspa_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  dcmd;
	dp_stat_t stat;

	// no wait states on the register port
	assign pready = 1'b1;

	// configuration registers and read mux
	aspa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: sequences exec, multiply, divide and apply steps
	aspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	// level, step, direction, counters, divider and result register
	aspa_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_item (cmd_item),
		.dcmd     (dcmd),
		.stat     (stat),
		.res_item (res_item)
	);

	// a command transfer always leaves the sequencer busy next cycle
	`ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	// a fresh result is only posted on the way back to idle
	`ASSERT_IMPLY(a_idle_on_result, clk, arst_n, $rose(res_valid), cmd_ready)
	// the result register is only loaded when it is free
	`ASSERT_IMPLY(a_result_free, clk, arst_n, dcmd.res_write, !res_valid || res_ready)

endmodule

`default_nettype wire

// ----- src/aspa_regs.sv -----
`default_nettype none

module aspa_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [aspa_pkg::ADDR_W-1:0] paddr,
	input  wire logic [aspa_pkg::DATA_W-1:0] pwdata,
	output logic      [aspa_pkg::DATA_W-1:0] prdata,
	output aspa_pkg::cfg_t                  cfg
);
	import aspa_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[4:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_min      <= STEP_MIN_RST;
			cfg_q.step_max      <= STEP_MAX_RST;
			cfg_q.step_factor   <= STEP_FACTOR_RST;
			cfg_q.count_limit   <= COUNT_LIMIT_RST;
			cfg_q.power_ceiling <= POWER_CEIL_RST;
			cfg_q.power_idle    <= POWER_IDLE_RST;
			cfg_q.bypass_bounds <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_STEP_MIN:    cfg_q.step_min      <= pwdata[7:0];
				REG_STEP_MAX:    cfg_q.step_max      <= pwdata[7:0];
				REG_STEP_FACTOR: cfg_q.step_factor   <= pwdata[7:0];
				REG_COUNT_LIMIT: cfg_q.count_limit   <= pwdata[7:0];
				REG_POWER_CEIL:  cfg_q.power_ceiling <= pwdata[7:0];
				REG_POWER_IDLE:  cfg_q.power_idle    <= pwdata[7:0];
				REG_BYPASS:      cfg_q.bypass_bounds <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_STEP_MIN:    prdata[7:0] = cfg_q.step_min;
			REG_STEP_MAX:    prdata[7:0] = cfg_q.step_max;
			REG_STEP_FACTOR: prdata[7:0] = cfg_q.step_factor;
			REG_COUNT_LIMIT: prdata[7:0] = cfg_q.count_limit;
			REG_POWER_CEIL:  prdata[7:0] = cfg_q.power_ceiling;
			REG_POWER_IDLE:  prdata[7:0] = cfg_q.power_idle;
			REG_BYPASS:      prdata[0]   = cfg_q.bypass_bounds;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/aspa_ctrl.sv -----
`default_nettype none

module aspa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	output logic                    res_valid,
	input  wire logic               res_ready,
	input  wire aspa_pkg::dp_stat_t stat,
	output aspa_pkg::dp_cmd_t       dcmd
);
	import aspa_pkg::*;

	localparam int ITER_W = $clog2(STEP_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DSTART,
		ST_DITER,
		ST_DEND,
		ST_APPLY,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [ITER_W-1:0]   iter_q;
	logic                res_valid_q;
	logic                res_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_free  = !res_valid_q || res_ready;

	always_comb begin
		dcmd           = '0;
		dcmd.load      = (state_q == ST_IDLE) && cmd_valid;
		dcmd.exec      = (state_q == ST_EXEC);
		dcmd.mul       = (state_q == ST_MUL);
		dcmd.div_start = (state_q == ST_DSTART);
		dcmd.div_iter  = (state_q == ST_DITER);
		dcmd.div_end   = (state_q == ST_DEND);
		dcmd.apply     = (state_q == ST_APPLY);
		dcmd.res_write = (state_q == ST_DONE) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (dcmd.res_write) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= stat.is_move ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					state_q <= stat.rev_hit ? ST_DSTART : ST_APPLY;
				end
				ST_DSTART: begin
					iter_q  <= '0;
					state_q <= ST_DITER;
				end
				ST_DITER: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(STEP_W - 1)) state_q <= ST_DEND;
				end
				ST_DEND: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/aspa_dpath.sv -----
`default_nettype none

module aspa_dpath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aspa_pkg::cfg_t      cfg,
	input  wire aspa_pkg::cmd_item_t cmd_item,
	input  wire aspa_pkg::dp_cmd_t   dcmd,
	output aspa_pkg::dp_stat_t       stat,
	output aspa_pkg::res_item_t      res_item
);
	import aspa_pkg::*;

	logic [CMD_W-1:0]  cmd_q;
	logic [7:0]        opnd_q;
	logic [LVL_W-1:0]  level_q;
	logic [STEP_W-1:0] step_q;
	dir_t              dir_q;
	logic [CNT_W-1:0]  same_q;
	logic [CNT_W-1:0]  rev_q;
	logic              same_hit_q;
	logic              rev_hit_q;
	logic              ok_q;
	logic              acc_q;
	logic [STEP_W:0]   rem_q;
	logic [STEP_W-1:0] quo_q;
	res_item_t         res_q;

	dir_t                dir_new;
	logic                is_move;
	logic [CNT_W-1:0]    same_n;
	logic [CNT_W-1:0]    rev_n;
	logic [2*STEP_W-1:0] prod;
	logic [STEP_W-1:0]   prod_lo;
	logic [STEP_W:0]     shifted;
	logic [STEP_W+1:0]   diff;
	logic [LVL_W:0]      sum_up;

	assign is_move = (cmd_q == CMD_INC) || (cmd_q == CMD_DEC);
	assign dir_new = (cmd_q == CMD_INC) ? DIR_UP : DIR_DOWN;
	assign same_n  = same_q + CNT_W'(dir_q == dir_new);
	assign rev_n   = rev_q + CNT_W'((dir_q != dir_new) && (dir_q != DIR_NONE));
	assign prod    = step_q * cfg.step_factor;
	assign prod_lo = prod[STEP_W-1:0];
	// restoring divider, one quotient bit a cycle
	assign shifted = {rem_q[STEP_W-1:0], quo_q[STEP_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, cfg.step_factor};
	assign sum_up  = {1'b0, level_q} + {1'b0, step_q};

	assign stat.is_move = is_move;
	assign stat.rev_hit = rev_hit_q;
	assign res_item     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= POWER_IDLE_RST;
			step_q  <= STEP_RST;
			dir_q   <= DIR_NONE;
			same_q  <= '0;
			rev_q   <= '0;
		end else begin
			if (dcmd.exec) begin
				if (is_move) begin
					dir_q  <= dir_new;
					same_q <= (same_n >= cfg.count_limit) ? '0 : same_n;
					rev_q  <= (rev_n >= cfg.count_limit) ? '0 : rev_n;
				end else begin
					case (cmd_q) inside
						CMD_OFF, CMD_FULL, CMD_LOAD_POWER: begin
							dir_q  <= DIR_NONE;
							same_q <= '0;
							rev_q  <= '0;
							if (cmd_q == CMD_OFF) begin
								level_q <= cfg.power_idle;
							end else if (cmd_q == CMD_FULL) begin
								level_q <= cfg.power_ceiling;
							end else begin
								level_q <= opnd_q;
							end
						end
						CMD_LOAD_STEP: begin
							if (step_in_bounds(opnd_q, cfg)) step_q <= opnd_q;
						end
						default: ;
					endcase
				end
			end
			if (dcmd.mul && same_hit_q && step_in_bounds(prod_lo, cfg)) begin
				step_q <= prod_lo;
			end
			if (dcmd.div_end && step_in_bounds(quo_q, cfg)) begin
				step_q <= quo_q;
			end
			if (dcmd.apply && ok_q) begin
				if (dir_q == DIR_UP) begin
					if (sum_up <= {1'b0, cfg.power_ceiling}) level_q <= sum_up[LVL_W-1:0];
				end else if (level_q >= step_q) begin
					level_q <= level_q - step_q;
				end
			end
		end
	end

	// payload and per-command scratch, no reset needed
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q  <= cmd_item.cmd;
			opnd_q <= cmd_item.operand;
		end
		if (dcmd.exec) begin
			same_hit_q <= is_move && (same_n >= cfg.count_limit);
			rev_hit_q  <= is_move && (rev_n >= cfg.count_limit);
			ok_q       <= 1'b1;
			case (cmd_q) inside
				CMD_OFF, CMD_FULL, CMD_LOAD_POWER: acc_q <= 1'b1;
				CMD_LOAD_STEP: acc_q <= step_in_bounds(opnd_q, cfg);
				default: acc_q <= 1'b0;
			endcase
		end
		if (dcmd.mul && same_hit_q) begin
			ok_q <= step_in_bounds(prod_lo, cfg);
		end
		if (dcmd.div_start) begin
			rem_q <= '0;
			quo_q <= step_q;
		end
		if (dcmd.div_iter) begin
			if (!diff[STEP_W+1]) begin
				rem_q <= diff[STEP_W:0];
				quo_q <= {quo_q[STEP_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[STEP_W-2:0], 1'b0};
			end
		end
		if (dcmd.div_end) begin
			ok_q <= step_in_bounds(quo_q, cfg);
		end
		if (dcmd.apply) begin
			if (!ok_q) begin
				acc_q <= 1'b0;
			end else if (dir_q == DIR_UP) begin
				acc_q <= (sum_up <= {1'b0, cfg.power_ceiling});
			end else begin
				acc_q <= (level_q >= step_q);
			end
		end
		if (dcmd.res_write) begin
			res_q.power_level <= level_q;
			res_q.step_size   <= step_q;
			res_q.accepted    <= acc_q;
		end
	end

endmodule

`default_nettype wire
